/* sv/tbwp_pkg.sv */
// Package for the tile background and window pixel block.
// Holds the shared constants, types and the shade-to-gray table.
// No dependencies.
package tbwp_pkg;

  localparam int unsigned ViewWidthDefault = 160;
  localparam int unsigned VramDepth        = 8192;
  localparam int unsigned VramAw           = $clog2(VramDepth);
  localparam int unsigned TileAw           = VramAw - 1;
  localparam int unsigned WindowLines      = 144;
  localparam logic [7:0]  WindowXOffset    = 8'd7;

  // Configuration register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegLcdControl = 3'd0;
  localparam logic [2:0] RegScrollX    = 3'd1;
  localparam logic [2:0] RegScrollY    = 3'd2;
  localparam logic [2:0] RegWindowX    = 3'd3;
  localparam logic [2:0] RegWindowY    = 3'd4;
  localparam logic [2:0] RegBgPalette  = 3'd5;

  localparam logic [7:0] LcdControlReset = 8'h91;
  localparam logic [7:0] BgPaletteReset  = 8'hfc;

  // lcd_control bit positions.
  localparam int unsigned LcdDisplayEn = 7;
  localparam int unsigned LcdWinMap    = 6;
  localparam int unsigned LcdWinEn     = 5;
  localparam int unsigned LcdTileData  = 4;
  localparam int unsigned LcdBgMap     = 3;
  localparam int unsigned LcdBgEn      = 0;

  typedef enum logic [1:0] {
    KindOff,
    KindBlack,
    KindTile
  } pix_kind_e;

  function automatic logic [7:0] gray_of(input logic [1:0] shade);
    logic [7:0] g;
    unique case (shade)
      2'd0: g = 8'hff;
      2'd1: g = 8'hcc;
      2'd2: g = 8'h77;
      2'd3: g = 8'h00;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

/* sv/tile_background_window_pixel.sv */
// Top level of the tile background and window pixel block.
// Depends on tbwp_pkg and instantiates tbwp_ram twice.
//
// One request is taken in every clock cycle and busy never rises. A write request
// (cmd_i low) stores mem_data_i at mem_addr_i and gives no result. A render request
// (cmd_i high) with column_i inside the view gives one result, shown on the result
// ports for one cycle with result_valid_o high; a render request outside the view
// gives none. The result comes out of the dependent chain map read, tile row read,
// palette lookup, each through a registered memory port or register. Results leave
// in request order and cannot be held off. The video memory is kept twice: a
// byte-wide copy that serves the tile map and a 16-bit copy that returns both
// bitplane bytes of a tile row in one read. Every write goes to both. Both copies
// are read-first, so a write accepted right behind a render never disturbs the
// older render. Memory has no reset; bytes must be written before they are
// rendered. Configuration is an APB-style port with registers at byte addresses
// 0 to 20; the user must see that it is written only while no render request is
// in flight, as the block itself does not enforce this.
module tile_background_window_pixel #(
  parameter int unsigned VIEW_WIDTH = tbwp_pkg::ViewWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [12:0] mem_addr_i,
  input  logic [7:0]  mem_data_i,
  input  logic [7:0]  line_i,
  input  logic [7:0]  column_i,
  // result channel
  output logic        result_valid_o,
  output logic [1:0]  shade_o,
  output logic [7:0]  gray_level_o,
  output logic        drawn_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VramAw = tbwp_pkg::VramAw;
  localparam int unsigned TileAw = tbwp_pkg::TileAw;

  // Configuration registers.
  logic [7:0] lcd_control_q, scroll_x_q, scroll_y_q, window_x_q, window_y_q, bg_palette_q;
  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_control_q <= tbwp_pkg::LcdControlReset;
      scroll_x_q    <= '0;
      scroll_y_q    <= '0;
      window_x_q    <= '0;
      window_y_q    <= '0;
      bg_palette_q  <= tbwp_pkg::BgPaletteReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tbwp_pkg::RegLcdControl: lcd_control_q <= pwdata[7:0];
        tbwp_pkg::RegScrollX:    scroll_x_q    <= pwdata[7:0];
        tbwp_pkg::RegScrollY:    scroll_y_q    <= pwdata[7:0];
        tbwp_pkg::RegWindowX:    window_x_q    <= pwdata[7:0];
        tbwp_pkg::RegWindowY:    window_y_q    <= pwdata[7:0];
        tbwp_pkg::RegBgPalette:  bg_palette_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      tbwp_pkg::RegLcdControl: prdata[7:0] = lcd_control_q;
      tbwp_pkg::RegScrollX:    prdata[7:0] = scroll_x_q;
      tbwp_pkg::RegScrollY:    prdata[7:0] = scroll_y_q;
      tbwp_pkg::RegWindowX:    prdata[7:0] = window_x_q;
      tbwp_pkg::RegWindowY:    prdata[7:0] = window_y_q;
      tbwp_pkg::RegBgPalette:  prdata[7:0] = bg_palette_q;
      default:                 prdata      = '0;
    endcase
  end

  // The pipeline never stalls, so a request is always taken.
  assign busy = 1'b0;

  logic accept, accept_write, accept_render, in_view;
  assign accept        = start && !busy;
  assign in_view       = {1'b0, column_i} < 9'(VIEW_WIDTH);
  assign accept_write  = accept && !cmd_i;
  assign accept_render = accept && cmd_i && in_view;

  // Stage 0: choose window or scrolled background and form the map address.
  logic [7:0]        win_x, px, py, win_dy;
  logic              in_window, map_sel;
  logic [VramAw-1:0] map_addr;
  tbwp_pkg::pix_kind_e kind;

  always_comb begin
    win_x     = window_x_q - tbwp_pkg::WindowXOffset;
    win_dy    = line_i - window_y_q;
    in_window = lcd_control_q[tbwp_pkg::LcdWinEn] && (line_i >= window_y_q)
             && ({1'b0, win_dy} < 9'(tbwp_pkg::WindowLines)) && (column_i >= win_x);
    if (in_window) begin
      px      = column_i - win_x;
      py      = win_dy;
      map_sel = lcd_control_q[tbwp_pkg::LcdWinMap];
    end else begin
      px      = column_i + scroll_x_q;
      py      = line_i + scroll_y_q;
      map_sel = lcd_control_q[tbwp_pkg::LcdBgMap];
    end
    // Maps sit at 0x1800 and 0x1c00: 32 tiles a row, one byte a tile.
    map_addr = {2'b11, map_sel, py[7:3], px[7:3]};
    if (!lcd_control_q[tbwp_pkg::LcdBgEn]) begin
      kind = tbwp_pkg::KindOff;
    end else if (!lcd_control_q[tbwp_pkg::LcdDisplayEn]) begin
      kind = tbwp_pkg::KindBlack;
    end else begin
      kind = tbwp_pkg::KindTile;
    end
  end

  logic [7:0] map_rdata;

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (tbwp_pkg::VramDepth)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (accept_write),
    .be_i    (1'b1),
    .waddr_i (mem_addr_i),
    .wdata_i (mem_data_i),
    .raddr_i (map_addr),
    .rdata_o (map_rdata)
  );

  logic                s1_valid_q;
  tbwp_pkg::pix_kind_e s1_kind_q;
  logic [2:0]          s1_px_q, s1_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_render;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= kind;
    s1_px_q   <= px[2:0];
    s1_py_q   <= py[2:0];
  end

  // Stage 1: tile row word address. Rows start at even bytes, so the two
  // bitplane bytes form one 16-bit word. Signed addressing centers on 0x1000,
  // which in word units flips the top bit of the sign-extended tile number.
  logic              tile_hi;
  logic [TileAw-1:0] row_raddr;

  assign tile_hi   = lcd_control_q[tbwp_pkg::LcdTileData] ? 1'b0 : ~map_rdata[7];
  assign row_raddr = {tile_hi, map_rdata, s1_py_q};

  logic [15:0] tile_rdata;

  tbwp_ram #(
    .WIDTH (16),
    .DEPTH (tbwp_pkg::VramDepth / 2)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (accept_write),
    .be_i    ({mem_addr_i[0], ~mem_addr_i[0]}),
    .waddr_i (mem_addr_i[VramAw-1:1]),
    .wdata_i ({mem_data_i, mem_data_i}),
    .raddr_i (row_raddr),
    .rdata_o (tile_rdata)
  );

  logic                s2_valid_q;
  tbwp_pkg::pix_kind_e s2_kind_q;
  logic [2:0]          s2_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_kind_q <= s1_kind_q;
    s2_px_q   <= s1_px_q;
  end

  // Stage 2: pick the pixel bit from both planes and apply the palette.
  logic [2:0] bit_sel;
  logic [1:0] color_idx, shade_d;
  logic [7:0] gray_d;
  logic       drawn_d;

  always_comb begin
    bit_sel   = 3'd7 - s2_px_q;
    color_idx = {tile_rdata[8 + 32'(bit_sel)], tile_rdata[bit_sel]};
    unique case (s2_kind_q)
      tbwp_pkg::KindOff: begin
        shade_d = 2'd0;
        gray_d  = 8'h00;
        drawn_d = 1'b0;
      end
      tbwp_pkg::KindBlack: begin
        shade_d = 2'd3;
        gray_d  = 8'h00;
        drawn_d = 1'b1;
      end
      tbwp_pkg::KindTile: begin
        shade_d = 2'(bg_palette_q >> {color_idx, 1'b0});
        gray_d  = tbwp_pkg::gray_of(shade_d);
        drawn_d = 1'b1;
      end
      default: begin
        shade_d = 2'd0;
        gray_d  = 8'h00;
        drawn_d = 1'b0;
      end
    endcase
  end

  logic       result_valid_q;
  logic [1:0] shade_q;
  logic [7:0] gray_level_q;
  logic       drawn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    shade_q      <= shade_d;
    gray_level_q <= gray_d;
    drawn_q      <= drawn_d;
  end

  assign result_valid_o = result_valid_q;
  assign shade_o        = shade_q;
  assign gray_level_o   = gray_level_q;
  assign drawn_o        = drawn_q;

  // A render inside the view always yields a result strobe.
  a_render_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_render |-> ##3 result_valid_o)
    else $error("render request lost in pipeline");

  // A memory write never yields a result.
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_write |-> ##3 !result_valid_o)
    else $error("write request produced a result");

  // An undrawn pixel is reported as shade zero with gray level zero.
  a_undrawn_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !drawn_o) |-> (shade_o == 2'd0 && gray_level_o == 8'h00))
    else $error("undrawn pixel carries a shade");

  // Each strobe traces back to an accepted render in the view.
  a_result_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept_render, 3))
    else $error("result without a render request");

endmodule

/* sv/tbwp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write at the same edge return the old contents.
// Depends on nothing.
module tbwp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [WIDTH/8-1:0]         be_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  localparam int unsigned NumBytes = WIDTH / 8;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    for (int b = 0; b < NumBytes; b++) begin
      if (we_i && be_i[b]) begin
        mem_q[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
